// ===== design/maze_hamiltonian_cycle_walker_defines.svh =====
// Assertion macros shared by the maze Hamiltonian cycle walker RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MAZE_HAMILTONIAN_CYCLE_WALKER_DEFINES_SVH
`define MAZE_HAMILTONIAN_CYCLE_WALKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MHCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MHCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mhcw_pkg.sv =====
// Types and constants of the maze Hamiltonian cycle walker.
// No dependencies; used by the top level and the walker.
`default_nettype none

package mhcw_pkg;

    localparam int CFG_W       = 7;
    localparam int DIM_RESET   = 64;
    localparam int MAZE_IDX_W  = 10;
    localparam int CELL_W      = 12;
    localparam int STEP_W      = 12;

    // link bit positions inside one maze entry
    localparam int LINK_RIGHT  = 0;
    localparam int LINK_DOWN   = 1;

    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_STEP       = 1'b1;

    localparam logic CFG_GRID_COLS = 1'b0;
    localparam logic CFG_GRID_ROWS = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT
    } t_dir;

    typedef enum logic {
        S_FETCH,
        S_ARMED
    } t_walk_state;

    typedef struct packed {
        logic                  operation;
        logic [MAZE_IDX_W-1:0] maze_cell;
        logic                  open_right;
        logic                  open_down;
    } t_step_req;

    typedef struct packed {
        logic [CELL_W-1:0] cycle_cell;
        logic [STEP_W-1:0] step_index;
        logic              lap_end;
    } t_step_rsp;

    typedef struct packed {
        logic             index;
        logic [CFG_W-1:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic restart;
        logic step;
    } t_walk_cmd;

endpackage

`default_nettype wire

// ===== design/mhcw_chan_if.sv =====
// Valid/ready channel carrying one payload of a package struct type.
// Depends on nothing; the payload type is set where the channel is declared.
`default_nettype none

interface mhcw_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/maze_hamiltonian_cycle_walker.sv =====
// Maze Hamiltonian cycle walker, top level.
// Usage:
//   i_cfg  : configuration write requests (index, value); always ready. Index
//            CFG_GRID_COLS sets the grid width, CFG_GRID_ROWS the height; the
//            low bit is dropped and the value clamped to 2..MAX (even), at most 126.
//   i_req  : load and step requests. A load stores one maze cell's right/down
//            links; a step emits the current cycle cell and then moves.
//   o_rsp  : one result per step: cycle_cell, step_index, lap_end.
// Fetch: after every move, load or config write the walker reads the maze
//   memory (two registered read ports) in its fetch state before it can decide
//   the next move, so it takes no new request while that read is under way.
// Result: a step result appears in the output register the cycle after the
//   request is accepted.
// Reset (synchronous, active low): sizes go to 64 by 64 clamped to MAX, the
//   walk restarts at cell 0 heading up. Maze contents hold no reset value.
// Stall: while a result waits unread, a new request is accepted only in the
//   cycle the receiver takes the waiting one.
`default_nettype none

`include "maze_hamiltonian_cycle_walker_defines.svh"

module maze_hamiltonian_cycle_walker #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhcw_chan_if.sink   i_req,
    mhcw_chan_if.source o_rsp,
    mhcw_chan_if.sink   i_cfg
);

    localparam int CLIM = (MAX_COLS / 2 * 2 < 126) ? MAX_COLS / 2 * 2 : 126;
    localparam int RLIM = (MAX_ROWS / 2 * 2 < 126) ? MAX_ROWS / 2 * 2 : 126;
    localparam int CDW  = $clog2(CLIM + 1);
    localparam int RDW  = $clog2(RLIM + 1);
    localparam int MAZE_DEPTH = (MAX_COLS / 2) * (MAX_ROWS / 2);
    localparam int AW   = (MAZE_DEPTH > 1) ? $clog2(MAZE_DEPTH) : 1;
    localparam int BW   = $clog2((CLIM / 2) * (RLIM / 2) + 1);
    localparam int IXW  = (AW > mhcw_pkg::MAZE_IDX_W) ? AW : mhcw_pkg::MAZE_IDX_W;
    localparam int COLS_RST = (mhcw_pkg::DIM_RESET > CLIM) ? CLIM : mhcw_pkg::DIM_RESET;
    localparam int ROWS_RST = (mhcw_pkg::DIM_RESET > RLIM) ? RLIM : mhcw_pkg::DIM_RESET;

    logic [CDW-1:0]            r_cols;
    logic [RDW-1:0]            r_rows;
    logic [BW-1:0]             r_blocks;
    logic                      r_out_valid;
    mhcw_pkg::t_step_rsp       r_out;

    logic [mhcw_pkg::CFG_W-1:0] cfg_even;
    logic [CDW-1:0]            cols_new;
    logic [RDW-1:0]            rows_new;
    logic                      cfg_acc;
    logic                      req_acc;
    logic                      load_acc;
    logic                      step_acc;
    logic                      load_in_range;
    logic [IXW-1:0]            idx_x;

    logic                      armed;
    mhcw_pkg::t_walk_cmd       walk_cmd;
    mhcw_pkg::t_step_rsp       walk_rsp;
    logic [AW-1:0]             addr_v;
    logic [AW-1:0]             addr_h;
    logic [1:0]                rdata_v;
    logic [1:0]                rdata_h;

    // Handshakes: config is always taken; requests only when the walker has
    // fresh link data and the output register is free or draining.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = armed && (!r_out_valid || o_rsp.ready);
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign req_acc     = i_req.valid && i_req.ready;
    assign load_acc    = req_acc && (i_req.data.operation == mhcw_pkg::OP_LOAD);
    assign step_acc    = req_acc && (i_req.data.operation == mhcw_pkg::OP_STEP);

    // Clamp a written size: drop the low bit, keep it within 2..limit.
    assign cfg_even = {i_cfg.data.value[mhcw_pkg::CFG_W-1:1], 1'b0};
    assign cols_new = (cfg_even < 7'd2) ? CDW'(2) :
                      (32'(cfg_even) > CLIM) ? CDW'(CLIM) : CDW'(cfg_even);
    assign rows_new = (cfg_even < 7'd2) ? RDW'(2) :
                      (32'(cfg_even) > RLIM) ? RDW'(RLIM) : RDW'(cfg_even);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CDW'(COLS_RST);
            r_rows <= RDW'(ROWS_RST);
        end else if (cfg_acc) begin
            if (i_cfg.data.index == mhcw_pkg::CFG_GRID_COLS) begin
                r_cols <= cols_new;
            end else begin
                r_rows <= rows_new;
            end
        end
    end

    // Maze block count, settled during the fetch cycle after any size change.
    always_ff @(posedge i_clk) begin
        r_blocks <= BW'(r_cols[CDW-1:1]) * BW'(r_rows[RDW-1:1]);
    end

    // Drop loads that fall outside the current maze; they still restart.
    assign idx_x         = IXW'(i_req.data.maze_cell);
    assign load_in_range = (32'(i_req.data.maze_cell) < 32'(r_blocks)) &&
                           (32'(i_req.data.maze_cell) < MAZE_DEPTH);

    assign walk_cmd.restart = cfg_acc || load_acc;
    assign walk_cmd.step    = step_acc;

    mhcw_maze_ram #(
        .DEPTH (MAZE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (load_acc && load_in_range),
        .i_waddr   (idx_x[AW-1:0]),
        .i_wdata   ({i_req.data.open_down, i_req.data.open_right}),
        .i_raddr_a (addr_v),
        .i_raddr_b (addr_h),
        .o_rdata_a (rdata_v),
        .o_rdata_b (rdata_h)
    );

    mhcw_walker #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (walk_cmd),
        .i_cols    (r_cols),
        .i_rows    (r_rows),
        .o_armed   (armed),
        .o_addr_v  (addr_v),
        .o_addr_h  (addr_h),
        .i_rdata_v (rdata_v),
        .i_rdata_h (rdata_h),
        .o_rsp     (walk_rsp)
    );

    // Output register: hold a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_out <= walk_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    `MHCW_ASSERT_NXT(a_step_fills_output, i_clk, i_rst_n, step_acc, r_out_valid, "step request left no result")
    `MHCW_ASSERT_NXT(a_request_refetches, i_clk, i_rst_n, req_acc, !i_req.ready, "request taken without a memory fetch")
    `MHCW_ASSERT_NXT(a_config_refetches, i_clk, i_rst_n, cfg_acc, !i_req.ready, "config write did not restart the walk")

endmodule

`default_nettype wire

// ===== design/mhcw_maze_ram.sv =====
// Maze link memory: one write port, two registered read ports.
// Standalone; instantiated by the top level.
`default_nettype none

module mhcw_maze_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [1:0]    o_rdata_a,
    output logic [1:0]    o_rdata_b
);

    logic [1:0] mem [DEPTH];
    logic [1:0] r_rdata_a;
    logic [1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== design/mhcw_walker.sv =====
// Walk position, heading and lap counter with the fetch/decide sequencer.
// Depends on mhcw_pkg; reads links from mhcw_maze_ram through the top level.
`default_nettype none

`include "maze_hamiltonian_cycle_walker_defines.svh"

module mhcw_walker #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int CLIM = (MAX_COLS / 2 * 2 < 126) ? MAX_COLS / 2 * 2 : 126,
    localparam int RLIM = (MAX_ROWS / 2 * 2 < 126) ? MAX_ROWS / 2 * 2 : 126,
    localparam int CDW  = $clog2(CLIM + 1),
    localparam int RDW  = $clog2(RLIM + 1),
    localparam int MAZE_DEPTH = (MAX_COLS / 2) * (MAX_ROWS / 2),
    localparam int AW   = (MAZE_DEPTH > 1) ? $clog2(MAZE_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mhcw_pkg::t_walk_cmd   i_cmd,
    input  logic [CDW-1:0]        i_cols,
    input  logic [RDW-1:0]        i_rows,
    output logic                  o_armed,
    output logic [AW-1:0]         o_addr_v,
    output logic [AW-1:0]         o_addr_h,
    input  logic [1:0]            i_rdata_v,
    input  logic [1:0]            i_rdata_h,
    output mhcw_pkg::t_step_rsp   o_rsp
);

    localparam int CPW = $clog2(CLIM);
    localparam int RPW = $clog2(RLIM);
    localparam int LW  = $clog2(CLIM * RLIM);
    localparam int TW  = $clog2(CLIM * RLIM + 1);
    localparam int LXW = (LW > mhcw_pkg::STEP_W) ? LW : mhcw_pkg::STEP_W;
    localparam int CW  = mhcw_pkg::CELL_W;

    mhcw_pkg::t_walk_state r_state, n_state;
    mhcw_pkg::t_dir        r_head, n_head;
    logic [RPW-1:0]        r_row, n_row;
    logic [CPW-1:0]        r_col, n_col;
    logic [LW-1:0]         r_lap, n_lap;
    logic [CW-1:0]         r_cell, n_cell;
    logic [AW-1:0]         r_blk, n_blk;
    logic [TW-1:0]         r_total;

    logic [CDW-2:0]        half_cols;
    logic [AW-1:0]         half_cols_a;
    logic                  link_v;
    logic                  link_h;
    logic [3:0]            move_ok;
    mhcw_pkg::t_dir        cand_left, cand_straight, cand_right, dir_sel;
    logic                  found;
    logic                  last;
    logic [LXW-1:0]        lap_x;

    // Block index of the current cell is kept incrementally; the two reads cover
    // the only links a move out of this cell can cross.
    assign half_cols   = i_cols[CDW-1:1];
    assign half_cols_a = AW'(half_cols);
    assign o_addr_v    = r_row[0] ? r_blk : r_blk - half_cols_a;
    assign o_addr_h    = r_col[0] ? r_blk : r_blk - AW'(1);
    assign link_v      = i_rdata_v[mhcw_pkg::LINK_DOWN];
    assign link_h      = i_rdata_h[mhcw_pkg::LINK_RIGHT];

    always_comb begin
        move_ok[mhcw_pkg::DIR_UP]    = r_row[0] | ((32'(r_row) >= 32'd2) & link_v);
        move_ok[mhcw_pkg::DIR_DOWN]  = ~r_row[0] |
                                       ((32'(r_row) + 32'd1 < 32'(i_rows)) & link_v);
        move_ok[mhcw_pkg::DIR_RIGHT] = ~r_col[0] |
                                       ((32'(r_col) + 32'd1 < 32'(i_cols)) & link_h);
        move_ok[mhcw_pkg::DIR_LEFT]  = r_col[0] | ((32'(r_col) >= 32'd2) & link_h);
    end

    assign cand_left     = mhcw_pkg::t_dir'(r_head + 2'd3);
    assign cand_straight = r_head;
    assign cand_right    = mhcw_pkg::t_dir'(r_head + 2'd1);

    always_comb begin
        found   = 1'b1;
        dir_sel = cand_left;
        if (move_ok[cand_left]) begin
            dir_sel = cand_left;
        end else if (move_ok[cand_straight]) begin
            dir_sel = cand_straight;
        end else if (move_ok[cand_right]) begin
            dir_sel = cand_right;
        end else begin
            found = 1'b0;
        end
    end

    assign last  = (TW'(r_lap) + TW'(1)) >= r_total;
    assign lap_x = LXW'(r_lap);

    assign o_armed          = (r_state == mhcw_pkg::S_ARMED);
    assign o_rsp.cycle_cell = r_cell;
    assign o_rsp.step_index = lap_x[mhcw_pkg::STEP_W-1:0];
    assign o_rsp.lap_end    = last;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_row   = r_row;
        n_col   = r_col;
        n_lap   = r_lap;
        n_cell  = r_cell;
        n_blk   = r_blk;
        case (r_state)
            mhcw_pkg::S_FETCH: begin
                n_state = mhcw_pkg::S_ARMED;
            end
            mhcw_pkg::S_ARMED: begin
                if (i_cmd.step) begin
                    n_state = mhcw_pkg::S_FETCH;
                    if (last) begin
                        n_head = mhcw_pkg::DIR_UP;
                        n_row  = '0;
                        n_col  = '0;
                        n_lap  = '0;
                        n_cell = '0;
                        n_blk  = '0;
                    end else begin
                        n_lap = r_lap + LW'(1);
                        if (found) begin
                            n_head = dir_sel;
                            case (dir_sel)
                                mhcw_pkg::DIR_UP: begin
                                    n_row  = r_row - RPW'(1);
                                    n_cell = r_cell - CW'(i_cols);
                                    if (!r_row[0]) n_blk = r_blk - half_cols_a;
                                end
                                mhcw_pkg::DIR_RIGHT: begin
                                    n_col  = r_col + CPW'(1);
                                    n_cell = r_cell + CW'(1);
                                    if (r_col[0]) n_blk = r_blk + AW'(1);
                                end
                                mhcw_pkg::DIR_DOWN: begin
                                    n_row  = r_row + RPW'(1);
                                    n_cell = r_cell + CW'(i_cols);
                                    if (r_row[0]) n_blk = r_blk + half_cols_a;
                                end
                                default: begin
                                    n_col  = r_col - CPW'(1);
                                    n_cell = r_cell - CW'(1);
                                    if (!r_col[0]) n_blk = r_blk - AW'(1);
                                end
                            endcase
                        end
                    end
                end
            end
            default: begin
                n_state = mhcw_pkg::S_FETCH;
            end
        endcase
        // restart wins: links or sizes changed, walk from cell 0 heading up
        if (i_cmd.restart) begin
            n_state = mhcw_pkg::S_FETCH;
            n_head  = mhcw_pkg::DIR_UP;
            n_row   = '0;
            n_col   = '0;
            n_lap   = '0;
            n_cell  = '0;
            n_blk   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhcw_pkg::S_FETCH;
            r_head  <= mhcw_pkg::DIR_UP;
            r_row   <= '0;
            r_col   <= '0;
            r_lap   <= '0;
            r_cell  <= '0;
            r_blk   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_row   <= n_row;
            r_col   <= n_col;
            r_lap   <= n_lap;
            r_cell  <= n_cell;
            r_blk   <= n_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= TW'(i_cols) * TW'(i_rows);
    end

    `MHCW_ASSERT_IMP(a_lap_below_total, i_clk, i_rst_n, r_state == mhcw_pkg::S_ARMED, TW'(r_lap) < r_total, "lap counter reached the cell count")

endmodule

`default_nettype wire
